// ===== sv/mwo_pkg.sv =====
// Shared types and constants for the multi-waveform oscillator.
// No dependencies; every other file in the block refers to it by scoped names.
package mwo_pkg;

   localparam int PHASE_BITS_DEF     = 32;
   localparam int SINE_ADDR_BITS_DEF = 10;

   localparam int STEP_W   = 32;
   localparam int AMP_W    = 15;
   localparam int WAVE_W   = 17;
   localparam int SAMPLE_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_WAVEFORM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE  = 2'd2;

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SAWTOOTH = 2'd1,
      WAVE_SQUARE   = 2'd2,
      WAVE_TRIANGLE = 2'd3
   } wave_sel_type;

   // Unit wave handed from the shaping stage to the scaling stage.
   typedef struct packed {
      logic                     use_sine;
      logic                     negate;
      logic signed [WAVE_W-1:0] other;
   } shape_type;

endpackage

// ===== sv/mwo_shape.sv =====
// Shaping stage: turns a phase into a unit wave in Q1.15, widened to 17 bits.
// Holds the quarter-wave sine ROM. Depends on mwo_pkg.
module mwo_shape #(
   parameter int PHASE_BITS     = mwo_pkg::PHASE_BITS_DEF,
   parameter int SINE_ADDR_BITS = mwo_pkg::SINE_ADDR_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             load,
   input  logic [PHASE_BITS-1:0]            phase,
   input  mwo_pkg::wave_sel_type            waveform,
   output mwo_pkg::shape_type               shape_ff,
   output logic [mwo_pkg::WAVE_W-1:0]       sine_ff
);

   localparam int ENTRIES = (1 << SINE_ADDR_BITS) + 1;
   localparam int ROM_AW  = SINE_ADDR_BITS + 1;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [mwo_pkg::WAVE_W-1:0] rom_type [ENTRIES];

   // Entry k is round(32768 * sin(pi/2 * k / 2^SINE_ADDR_BITS)), found with a
   // truncated Q30 Taylor series up to the fifteenth power.
   function automatic logic [mwo_pkg::WAVE_W-1:0] sine_entry(input int k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      logic [63:0]        v;
      x    = (HALF_PI_Q30 * 64'(k)) >> SINE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = '0;
      for (int n = 0; n < 8; n++) begin
         if ((n % 2) == 0) begin
            acc = acc + $signed(term);
         end else begin
            acc = acc - $signed(term);
         end
         term = (term * x2) >> 30;
         term = term / 64'((2 * n + 2) * (2 * n + 3));
      end
      if (acc < 0) begin
         acc = '0;
      end
      v = ((64'(acc) * 64'd32768) + (64'd1 << 29)) >> 30;
      if (v > 64'd32768) begin
         v = 64'd32768;
      end
      return v[mwo_pkg::WAVE_W-1:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type t;
      for (int k = 0; k < ENTRIES; k++) begin
         t[k] = sine_entry(k);
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [1:0]                         quad;
   logic [SINE_ADDR_BITS-1:0]          idx;
   logic [ROM_AW-1:0]                  rom_addr;
   logic [15:0]                        p16;
   logic signed [18:0]                 twice;
   logic signed [18:0]                 tri_wave;
   logic signed [mwo_pkg::WAVE_W-1:0]  other;
   mwo_pkg::shape_type                 shape_in;

   assign quad = phase[PHASE_BITS-1 -: 2];
   assign idx  = phase[PHASE_BITS-3 -: SINE_ADDR_BITS];
   assign p16  = phase[PHASE_BITS-1 -: 16];

   // Odd quadrants read the table from the far end.
   always_comb begin
      if (quad[0]) begin
         rom_addr = (ROM_AW'(1) << SINE_ADDR_BITS) - ROM_AW'(idx);
      end else begin
         rom_addr = ROM_AW'(idx);
      end
   end

   assign twice = 19'(p16) <<< 1;

   always_comb begin
      if (p16 <= 16'd16384) begin
         tri_wave = twice;
      end else if (p16 <= 16'd49152) begin
         tri_wave = 19'sd65536 - twice;
      end else begin
         tri_wave = twice - 19'sd131072;
      end
   end

   always_comb begin
      case (waveform)
         mwo_pkg::WAVE_SAWTOOTH: other = $signed(17'(p16)) - 17'sd32768;
         mwo_pkg::WAVE_SQUARE:   other = p16[15] ? -17'sd32768 : 17'sd32768;
         mwo_pkg::WAVE_TRIANGLE: other = tri_wave[mwo_pkg::WAVE_W-1:0];
         default:                other = '0;
      endcase
   end

   always_comb begin
      shape_in.use_sine = (waveform == mwo_pkg::WAVE_SINE);
      shape_in.negate   = quad[1];
      shape_in.other    = other;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         shape_ff <= shape_in;
         sine_ff  <= SINE_ROM[rom_addr];
      end
   end

endmodule

// ===== sv/mwo_scale.sv =====
// Scaling stage: multiplies the unit wave by the amplitude and rounds half up
// into the registered 16-bit sample. Depends on mwo_pkg.
module mwo_scale (
   input  logic                                  clock,
   input  logic                                  load,
   input  mwo_pkg::shape_type                    shape,
   input  logic [mwo_pkg::WAVE_W-1:0]            sine,
   input  logic [mwo_pkg::AMP_W-1:0]             amplitude,
   output logic signed [mwo_pkg::SAMPLE_W-1:0]   sample_ff
);

   localparam int PROD_W = mwo_pkg::AMP_W + 1 + mwo_pkg::WAVE_W;

   logic signed [mwo_pkg::WAVE_W-1:0]   wave;
   logic signed [PROD_W-1:0]            prod;
   logic signed [PROD_W-1:0]            rounded;
   logic signed [mwo_pkg::SAMPLE_W-1:0] sample_in;

   always_comb begin
      if (!shape.use_sine) begin
         wave = shape.other;
      end else if (shape.negate) begin
         wave = -$signed(sine);
      end else begin
         wave = $signed(sine);
      end
   end

   // The product stays within 31 bits, so bits 30..15 hold the floor.
   assign prod      = $signed({1'b0, amplitude}) * wave;
   assign rounded   = prod + PROD_W'(16384);
   assign sample_in = rounded[30:15];

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= sample_in;
      end
   end

endmodule

// ===== sv/multi_waveform_oscillator.sv =====
// Top level of the multi-waveform direct digital synthesis oscillator.
// Uses mwo_pkg, mwo_shape and mwo_scale.

// Each accepted request beat produces exactly one response beat holding one
// signed 16-bit sample. A PHASE_BITS-wide accumulator advances by phase_step
// for every beat; the phase before the advance forms the sample, and a set
// restart bit zeroes the phase before that sample is formed. The waveform
// register picks sine (truncated lookup in a quarter-wave ROM of
// 2^SINE_ADDR_BITS + 1 entries), sawtooth, square or triangle, and the result
// is amplitude times the unit wave, rounded half up. The block takes a new
// beat in every cycle unless a response stall holds it: the path is the
// phase accumulator and ROM read into the shaping register, then one 16 by
// 17 bit multiply into the output register. Throughput is one beat per
// cycle, limited only by response stalls. The configuration registers are
// written through the csr_ port and should be changed only while no beat
// is in flight.
module multi_waveform_oscillator #(
   parameter int PHASE_BITS     = mwo_pkg::PHASE_BITS_DEF,
   parameter int SINE_ADDR_BITS = mwo_pkg::SINE_ADDR_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mwo_pkg::SAMPLE_W-1:0]   rsp_sample,
   input  logic                                  csr_write_en,
   input  logic [mwo_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mwo_pkg::CSR_DATA_W-1:0]        csr_data
);

   // Configuration registers.
   mwo_pkg::wave_sel_type             waveform_ff;
   logic [mwo_pkg::STEP_W-1:0]        phase_step_ff;
   logic [mwo_pkg::AMP_W-1:0]         amplitude_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff   <= mwo_pkg::WAVE_SINE;
         phase_step_ff <= '0;
         amplitude_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            mwo_pkg::CSR_WAVEFORM:   waveform_ff   <= mwo_pkg::wave_sel_type'(csr_data[1:0]);
            mwo_pkg::CSR_PHASE_STEP: phase_step_ff <= csr_data[mwo_pkg::STEP_W-1:0];
            mwo_pkg::CSR_AMPLITUDE:  amplitude_ff  <= csr_data[mwo_pkg::AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake. The shaping stage moves on when the output register is free
   // or is being emptied this cycle, so a held response never stops the
   // stage behind it from filling.
   logic accept;
   logic out_load;
   logic shape_valid_ff;
   logic shape_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   assign out_load  = shape_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = shape_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         shape_valid_in = 1'b1;
      end else if (out_load) begin
         shape_valid_in = 1'b0;
      end else begin
         shape_valid_in = shape_valid_ff;
      end
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         shape_valid_ff <= shape_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Phase accumulator. The step is cut or zero-extended to the accumulator
   // width, which wraps it modulo the phase range.
   logic [PHASE_BITS-1:0] phase_acc_ff;
   logic [PHASE_BITS-1:0] phase_acc_in;
   logic [PHASE_BITS-1:0] phase_now;

   assign phase_now = req_restart ? '0 : phase_acc_ff;

   always_comb begin
      if (accept) begin
         phase_acc_in = phase_now + PHASE_BITS'(phase_step_ff);
      end else begin
         phase_acc_in = phase_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
      end else begin
         phase_acc_ff <= phase_acc_in;
      end
   end

   mwo_pkg::shape_type              shape;
   logic [mwo_pkg::WAVE_W-1:0]      sine;

   mwo_shape #(
      .PHASE_BITS     (PHASE_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) u_shape (
      .clock    (clock),
      .load     (accept),
      .phase    (phase_now),
      .waveform (waveform_ff),
      .shape_ff (shape),
      .sine_ff  (sine)
   );

   mwo_scale u_scale (
      .clock     (clock),
      .load      (out_load),
      .shape     (shape),
      .sine      (sine),
      .amplitude (amplitude_ff),
      .sample_ff (rsp_sample)
   );

endmodule

// ===== test/multi_waveform_oscillator_tb.sv =====
// Self-checking testbench for the multi-waveform DDS oscillator.
// Depends on mwo_pkg and multi_waveform_oscillator, which needs mwo_shape and mwo_scale.
module multi_waveform_oscillator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PH_W = mwo_pkg::PHASE_BITS_DEF;
   localparam int SA_W = mwo_pkg::SINE_ADDR_BITS_DEF;
   localparam int QUARTER_LAST = 1 << SA_W;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BEATS = 700;
   localparam int CALM_BEATS = 100;

   // The block has three registers; the fourth index is left unused and any write
   // to it must be dropped.
   localparam logic [mwo_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // One line of the directed stimulus: either a register write or a request
   // beat, where a beat may carry a sample that can be written down by hand.
   typedef struct packed {
      logic                                 is_csr;
      logic [mwo_pkg::CSR_IDX_W-1:0]        idx;
      logic [mwo_pkg::CSR_DATA_W-1:0]       data;
      logic                                 restart;
      logic                                 known;
      logic signed [mwo_pkg::SAMPLE_W-1:0]  sample;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic                                   req_restart = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic signed [mwo_pkg::SAMPLE_W-1:0]    rsp_sample;
   logic                                   csr_write_en = 1'b0;
   logic [mwo_pkg::CSR_IDX_W-1:0]          csr_index = '0;
   logic [mwo_pkg::CSR_DATA_W-1:0]         csr_data = '0;

   always #5 clock = ~clock;

   multi_waveform_oscillator uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_sample   (rsp_sample),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // ------------------------------------------------------------------
   // Oscillator model: our own copy of the registers and the phase.
   // ------------------------------------------------------------------
   mwo_pkg::wave_sel_type          osc_wave  = mwo_pkg::WAVE_SINE;
   logic [mwo_pkg::STEP_W-1:0]     osc_step  = '0;
   logic [mwo_pkg::AMP_W-1:0]      osc_amp   = '0;
   logic [PH_W-1:0]                osc_phase = '0;
   int                             quarter_sine [0:QUARTER_LAST];

   // Samples predicted for accepted request beats, oldest first.
   logic signed [mwo_pkg::SAMPLE_W-1:0] sample_due [$];

   int beats_sent      = 0;
   int samples_checked = 0;
   int mismatches      = 0;
   int csr_writes      = 0;
   int req_odds        = 0;
   int rsp_odds        = 0;
   logic calm          = 1'b0;

   // The quarter-wave table is a Q30 Taylor series of sin(x), truncated at every
   // term, then scaled to Q15 with rounding and held to 32768 at most.
   function automatic void build_quarter_sine();
      longint unsigned x, x2, term, k, n;
      longint acc, v;
      for (k = 0; k <= QUARTER_LAST; k++) begin
         x = (HALF_PI_Q30 * k) >> SA_W;
         x2 = (x * x) >> 30;
         term = x;
         acc = 0;
         for (n = 0; n < 8; n++) begin
            if (n[0] == 1'b0) acc += longint'(term);
            else acc -= longint'(term);
            term = (term * x2) >> 30;
            term = term / ((2 * n + 2) * (2 * n + 3));
         end
         if (acc < 0) acc = 0;
         v = longint'(($unsigned(acc) * 64'd32768 + (64'd1 << 29)) >> 30);
         if (v > 32768) v = 32768;
         quarter_sine[k] = int'(v);
      end
   endfunction

   // Unit wave in Q1.15 widened so that +1.0 and -1.0 are both exact.
   function automatic int unit_wave(logic [PH_W-1:0] ph);
      int p16;
      int addr;
      logic [1:0] quad;
      p16 = ph[PH_W-1 -: 16];
      quad = ph[PH_W-1 -: 2];
      addr = ph[PH_W-3 -: SA_W];
      case (osc_wave)
         mwo_pkg::WAVE_SINE: begin
            if (quad[0]) addr = QUARTER_LAST - addr;
            return quad[1] ? -quarter_sine[addr] : quarter_sine[addr];
         end
         mwo_pkg::WAVE_SAWTOOTH: return p16 - 32768;
         mwo_pkg::WAVE_SQUARE: return (p16 < 32768) ? 32768 : -32768;
         default: begin
            if (p16 <= 16384) return 2 * p16;
            if (p16 <= 49152) return 65536 - 2 * p16;
            return 2 * p16 - 131072;
         end
      endcase
   endfunction

   // Forms the sample for one beat and advances the phase afterwards.
   function automatic logic signed [mwo_pkg::SAMPLE_W-1:0] next_sample(logic restart);
      longint prod;
      longint unsigned biased;
      if (restart) osc_phase = '0;
      prod = longint'(osc_amp) * longint'(unit_wave(osc_phase));
      biased = prod + 16384 + (64'sd1 << 30);
      osc_phase = osc_phase + osc_step;
      return mwo_pkg::SAMPLE_W'((biased >> 15) - 32768);
   endfunction

   function automatic void apply_csr(logic [mwo_pkg::CSR_IDX_W-1:0] idx,
                                     logic [mwo_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         mwo_pkg::CSR_WAVEFORM:   osc_wave = mwo_pkg::wave_sel_type'(data[1:0]);
         mwo_pkg::CSR_PHASE_STEP: osc_step = data[mwo_pkg::STEP_W-1:0];
         mwo_pkg::CSR_AMPLITUDE:  osc_amp = data[mwo_pkg::AMP_W-1:0];
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Directed stimulus. Rows with a known sample are after reset, at the
   // waveform extremes or at zero amplitude; the rest go to the model.
   // ------------------------------------------------------------------
   function automatic stim_row_type csr_row(logic [mwo_pkg::CSR_IDX_W-1:0] idx,
                                            logic [mwo_pkg::CSR_DATA_W-1:0] data);
      return '{is_csr: 1'b1, idx: idx, data: data, restart: 1'b0, known: 1'b0, sample: '0};
   endfunction

   function automatic stim_row_type beat_row(logic restart);
      return '{is_csr: 1'b0, idx: '0, data: '0, restart: restart, known: 1'b0, sample: '0};
   endfunction

   function automatic stim_row_type known_row(logic restart,
                                              logic signed [mwo_pkg::SAMPLE_W-1:0] sample);
      return '{is_csr: 1'b0, idx: '0, data: '0, restart: restart, known: 1'b1, sample: sample};
   endfunction

   localparam int DIR_ROWS = 36;
   stim_row_type dir_tab [DIR_ROWS] = '{
      // Straight out of reset the amplitude is zero, so every sample is zero.
      known_row(1'b0, 16'sd0),
      known_row(1'b1, 16'sd0),
      // Full-scale square: the positive and negative peaks round to +/-32767.
      csr_row(mwo_pkg::CSR_AMPLITUDE, 32'd32767),
      csr_row(mwo_pkg::CSR_WAVEFORM, 32'(mwo_pkg::WAVE_SQUARE)),
      known_row(1'b1, 16'sd32767),
      csr_row(mwo_pkg::CSR_PHASE_STEP, 32'h8000_0000),
      known_row(1'b1, 16'sd32767),
      known_row(1'b0, -16'sd32767),
      // Sawtooth at its start and at half a cycle.
      csr_row(mwo_pkg::CSR_WAVEFORM, 32'(mwo_pkg::WAVE_SAWTOOTH)),
      known_row(1'b1, -16'sd32767),
      known_row(1'b0, 16'sd0),
      // Triangle at each quarter of the cycle, then wrapping round to zero.
      csr_row(mwo_pkg::CSR_PHASE_STEP, 32'h4000_0000),
      csr_row(mwo_pkg::CSR_WAVEFORM, 32'(mwo_pkg::WAVE_TRIANGLE)),
      known_row(1'b1, 16'sd0),
      known_row(1'b0, 16'sd32767),
      known_row(1'b0, 16'sd0),
      known_row(1'b0, -16'sd32767),
      known_row(1'b0, 16'sd0),
      // Sine at each quadrant boundary; the peaks come from the table.
      csr_row(mwo_pkg::CSR_WAVEFORM, 32'(mwo_pkg::WAVE_SINE)),
      known_row(1'b1, 16'sd0),
      beat_row(1'b0),
      known_row(1'b0, 16'sd0),
      beat_row(1'b0),
      // Largest step, so the phase runs backwards, at the smallest amplitude.
      csr_row(mwo_pkg::CSR_PHASE_STEP, 32'hFFFF_FFFF),
      csr_row(mwo_pkg::CSR_AMPLITUDE, 32'd1),
      known_row(1'b1, 16'sd0),
      beat_row(1'b0),
      beat_row(1'b0),
      // An unused index is dropped; over-wide values keep only their low bits.
      csr_row(CSR_UNUSED, 32'hFFFF_FFFF),
      csr_row(mwo_pkg::CSR_WAVEFORM, 32'hFFFF_FFFD),
      csr_row(mwo_pkg::CSR_AMPLITUDE, 32'hFFFF_C000),
      beat_row(1'b0),
      beat_row(1'b1),
      // Zero amplitude silences even a full-scale square.
      csr_row(mwo_pkg::CSR_AMPLITUDE, 32'd0),
      csr_row(mwo_pkg::CSR_WAVEFORM, 32'(mwo_pkg::WAVE_SQUARE)),
      known_row(1'b0, 16'sd0)
   };

   // ------------------------------------------------------------------
   // Request side. Each task starts in the time step of a rising edge, so a
   // signal never receives two nonblocking assignments in one step.
   // ------------------------------------------------------------------
   task automatic send_beat(logic restart, logic known,
                            logic signed [mwo_pkg::SAMPLE_W-1:0] sample);
      logic signed [mwo_pkg::SAMPLE_W-1:0] predicted;
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall !== 1'b0);
      // The beat has gone in; the model still runs for a hand-written row so
      // that its phase stays in step with the block.
      predicted = next_sample(restart);
      sample_due.push_back(known ? sample : predicted);
      beats_sent++;
   endtask

   task automatic req_gap(int cycles);
      req_valid <= 1'b0;
      req_restart <= 1'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // Stops sending and waits until every predicted sample has come back, which
   // leaves the block idle and safe for register writes.
   task automatic drain_samples();
      req_valid <= 1'b0;
      do @(posedge clock); while (sample_due.size() != 0);
   endtask

   task automatic csr_write(logic [mwo_pkg::CSR_IDX_W-1:0] idx,
                            logic [mwo_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      apply_csr(idx, data);
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (req_odds != 0 && $urandom_range(0, 99) < req_odds) req_gap($urandom_range(1, 19));
   endtask

   // ------------------------------------------------------------------
   // Response side: stall in bursts of random length, never once the run
   // has gone calm.
   // ------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_odds != 0 && $urandom_range(0, 99) < rsp_odds) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every response beat is matched against the oldest predicted sample.
   always @(posedge clock) begin
      logic signed [mwo_pkg::SAMPLE_W-1:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (sample_due.size() == 0) begin
            mismatches++;
            $display("%0t: response beat with no sample pending, expected none, actual %0d",
                     $time, rsp_sample);
         end else begin
            want = sample_due.pop_front();
            samples_checked++;
            if (rsp_sample !== want) begin
               mismatches++;
               $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, rsp_sample);
            end
         end
      end
   end

   // The run is stuck if neither channel has moved a beat for too long.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      int burst;
      int pause_at;
      build_quarter_sine();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      req_odds = 20;
      rsp_odds = 20;
      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_csr) begin
            drain_samples();
            csr_write(dir_tab[i].idx, dir_tab[i].data);
         end else begin
            maybe_gap();
            send_beat(dir_tab[i].restart, dir_tab[i].known, dir_tab[i].sample);
         end
      end

      // Random phases: a fresh setting, then a run of beats with random restarts.
      // The step is often small so that the waveform is swept smoothly, and the
      // extremes of step and amplitude turn up regularly.
      while (beats_sent < RANDOM_BEATS) begin
         drain_samples();
         if ($urandom_range(0, 3) != 0) csr_write(mwo_pkg::CSR_WAVEFORM, $urandom);
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0: csr_write(mwo_pkg::CSR_PHASE_STEP, 32'd0);
               1: csr_write(mwo_pkg::CSR_PHASE_STEP, 32'hFFFF_FFFF);
               2, 3: csr_write(mwo_pkg::CSR_PHASE_STEP, $urandom_range(0, 32'h00FF_FFFF));
               default: csr_write(mwo_pkg::CSR_PHASE_STEP, $urandom);
            endcase
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0: csr_write(mwo_pkg::CSR_AMPLITUDE, 32'd0);
               1: csr_write(mwo_pkg::CSR_AMPLITUDE, 32'd32767);
               2: csr_write(mwo_pkg::CSR_AMPLITUDE, $urandom);
               default: csr_write(mwo_pkg::CSR_AMPLITUDE, $urandom_range(0, 32767));
            endcase
         end
         if ($urandom_range(0, 7) == 0) csr_write(CSR_UNUSED, $urandom);

         // Some phases run without any idling at all.
         case ($urandom_range(0, 3))
            0: req_odds = 0;
            1: req_odds = 5;
            default: req_odds = 25;
         endcase
         case ($urandom_range(0, 3))
            0: rsp_odds = 0;
            1: rsp_odds = 5;
            default: rsp_odds = 25;
         endcase

         burst = $urandom_range(10, 50);
         pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, burst - 1) : -1;
         for (int i = 0; i < burst; i++) begin
            maybe_gap();
            // Now and then the sender holds back until the block has emptied.
            if (i == pause_at) drain_samples();
            send_beat($urandom_range(0, 19) == 0, 1'b0, '0);
         end
      end

      // Final stretch at full rate on both sides with a full-scale sine.
      drain_samples();
      calm = 1'b1;
      req_odds = 0;
      rsp_odds = 0;
      csr_write(mwo_pkg::CSR_WAVEFORM, 32'(mwo_pkg::WAVE_SINE));
      csr_write(mwo_pkg::CSR_AMPLITUDE, 32'd32767);
      csr_write(mwo_pkg::CSR_PHASE_STEP, $urandom);
      for (int i = 0; i < CALM_BEATS; i++) send_beat($urandom_range(0, 19) == 0, 1'b0, '0);

      drain_samples();
      repeat (8) @(posedge clock);
      if (sample_due.size() != 0)
         $display("%0t: %0d samples never arrived", $time, sample_due.size());

      $display("Sent %0d request beats and checked %0d samples across %0d register writes,",
               beats_sent, samples_checked, csr_writes);
      $display("covering all four waveforms, restarts, step and amplitude extremes and stalls.");
      if (mismatches == 0 && sample_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
